@@ src/pfc_pkg.sv @@
// Shared types for the pixel format converter.
// Holds the source format codes, the pixel kind encoding and the queue entry type.
// No dependencies.
`default_nettype none

package pfc_pkg;

	localparam int unsigned FMT_W       = 5;
	localparam int unsigned NUM_FORMATS = 21;

	localparam logic [FMT_W-1:0] FMT_GRAY8     = 5'd0;
	localparam logic [FMT_W-1:0] FMT_BGR_FIRST = 5'd1;
	localparam logic [FMT_W-1:0] FMT_BGR_LAST  = 5'd10;
	localparam logic [FMT_W-1:0] FMT_RGB_FIRST = 5'd11;
	localparam logic [FMT_W-1:0] FMT_RGB_LAST  = 5'd20;
	localparam logic [FMT_W-1:0] FMT_RESET     = 5'd7;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [3:0] {
		K_555X  = 4'd0,
		K_565   = 4'd1,
		K_888   = 4'd2,
		K_888X  = 4'd3,
		K_4444  = 4'd4,
		K_5551  = 4'd5,
		K_8888  = 4'd6,
		K_N4444 = 4'd7,
		K_N5551 = 4'd8,
		K_N8888 = 4'd9,
		K_GRAY  = 4'd10
	} kind_t;

	// one gathered pixel on its way to the unpacker
	typedef struct packed {
		kind_t       kind;
		logic        rgb_order;
		logic [31:0] word;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

`default_nettype wire

@@ src/pixel_format_to_rgba8888_top.sv @@
// A pixel's last byte completes its queue entry, which then moves into the output register behind pixel_valid.
// Takes one byte per cycle while not stalled; a pixel is 1, 2, 3 or 4 bytes by format.
// The front end stalls only when the FIFO_DEPTH-entry queue is full.
// Reset (arst_n low): format 7 (BGRA8888), gather state, queue and output valid cleared.
// cfg_ready is high while no pixel is queued or waiting at the output.
// Depends on pfc_pkg, pfc_front, pfc_fifo, pfc_back.
`default_nettype none

module pixel_format_to_rgba8888_top #(
	parameter int unsigned FIFO_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [4:0] pixel_format,
	input  wire logic       data_valid,
	output logic            data_stall,
	input  wire logic [7:0] data_byte,
	output logic            pixel_valid,
	input  wire logic       pixel_stall,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue,
	output logic [7:0]      alpha
);
	import pfc_pkg::*;

	fifo_status_t q_status;
	item_t        push_item;
	item_t        head;
	logic         push;
	logic         pop;
	logic         cfg_we;

	assign cfg_ready = q_status.empty && !pixel_valid;
	assign cfg_we    = cfg_valid && cfg_ready;

	pfc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.pixel_format (pixel_format),
		.data_valid   (data_valid),
		.data_byte    (data_byte),
		.data_stall   (data_stall),
		.q_status     (q_status),
		.push         (push),
		.item         (push_item)
	);

	pfc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	pfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.q_item      (head),
		.pop         (pop),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall)
	);

endmodule

`default_nettype wire

@@ src/pfc_front.sv @@
// Front end: format register, byte gathering and pixel classification.
// Pushes one item_t per completed pixel into the queue.
// Depends on pfc_pkg.
`default_nettype none

module pfc_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [4:0]                pixel_format,
	input  wire logic                      data_valid,
	input  wire logic [7:0]                data_byte,
	output logic                           data_stall,
	input  wire pfc_pkg::fifo_status_t     q_status,
	output logic                           push,
	output pfc_pkg::item_t                 item
);
	import pfc_pkg::*;

	logic [FMT_W-1:0] fmt_q;
	logic [23:0]      gathered_q;
	logic [1:0]       pos_q;

	kind_t       kind;
	logic        rgb_order;
	logic        fmt_ok;
	logic [2:0]  nbytes;
	logic        accept;
	logic        last;
	logic [31:0] word;

	always_comb begin
		kind      = K_GRAY;
		rgb_order = 1'b0;
		fmt_ok    = 1'b1;
		if (fmt_q == FMT_GRAY8) begin
			kind = K_GRAY;
		end else if (fmt_q <= FMT_BGR_LAST) begin
			kind = kind_t'(4'(fmt_q - FMT_BGR_FIRST));
		end else if (fmt_q <= FMT_RGB_LAST) begin
			kind      = kind_t'(4'(fmt_q - FMT_RGB_FIRST));
			rgb_order = 1'b1;
		end else begin
			fmt_ok = 1'b0;
		end
	end

	always_comb begin
		unique case (kind)
			K_GRAY:                  nbytes = 3'd1;
			K_888:                   nbytes = 3'd3;
			K_888X, K_8888, K_N8888: nbytes = 3'd4;
			default:                 nbytes = 3'd2;
		endcase
		if (!fmt_ok) begin
			nbytes = 3'd0;
		end
	end

	assign data_stall = q_status.full;
	assign accept     = data_valid && !data_stall;
	assign last       = ({1'b0, pos_q} + 3'd1) >= nbytes;
	assign word       = {8'd0, gathered_q} | ({24'd0, data_byte} << {pos_q, 3'b000});

	assign push           = accept && fmt_ok && last;
	assign item.kind      = kind;
	assign item.rgb_order = rgb_order;
	assign item.word      = word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q      <= FMT_RESET;
			gathered_q <= '0;
			pos_q      <= '0;
		end else if (cfg_we) begin
			fmt_q      <= pixel_format;
			gathered_q <= '0;
			pos_q      <= '0;
		end else if (accept) begin
			if (!fmt_ok || last) begin
				gathered_q <= '0;
				pos_q      <= '0;
			end else begin
				gathered_q <= word[23:0];
				pos_q      <= pos_q + 2'd1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_unknown_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fmt_ok |-> (pos_q == 2'd0 && gathered_q == 24'd0))
		else $error("gather state not clear for unknown format");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fmt_ok |-> ({1'b0, pos_q} < nbytes))
		else $error("byte position past pixel size");
`endif

endmodule

`default_nettype wire

@@ src/pfc_fifo.sv @@
// Small queue between the gathering front end and the unpacking back end.
// Register array with read and write pointers and an occupancy count.
// Depends on pfc_pkg.
`default_nettype none

module pfc_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire pfc_pkg::item_t        push_item,
	input  wire logic                  pop,
	output pfc_pkg::item_t             head,
	output pfc_pkg::fifo_status_t      status
);
	import pfc_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

@@ src/pfc_back.sv @@
// Back end: unpacks a gathered pixel into 8-bit RGBA and holds it in the output register.
// Pops the queue whenever the output register is free or being drained.
// Depends on pfc_pkg.
`default_nettype none

module pfc_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pfc_pkg::fifo_status_t q_status,
	input  wire pfc_pkg::item_t        q_item,
	output logic                       pop,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue,
	output logic [7:0]                 alpha,
	output logic                       pixel_valid,
	input  wire logic                  pixel_stall
);
	import pfc_pkg::*;

	logic [31:0] w;
	logic [7:0]  lo, g, hi, a;
	logic        valid_q;

	assign w = q_item.word;

	always_comb begin
		lo = w[7:0];
		g  = w[15:8];
		hi = w[23:16];
		a  = ALPHA_OPAQUE;
		unique case (q_item.kind)
			K_555X, K_5551, K_N5551: begin
				lo = {w[4:0], 3'b000};
				g  = {w[9:5], 3'b000};
				hi = {w[14:10], 3'b000};
				if (q_item.kind == K_5551) begin
					a = w[15] ? ALPHA_OPAQUE : 8'h00;
				end else if (q_item.kind == K_N5551) begin
					a = w[15] ? 8'h00 : ALPHA_OPAQUE;
				end
			end
			K_565: begin
				lo = {w[4:0], 3'b000};
				g  = {w[10:5], 2'b00};
				hi = {w[15:11], 3'b000};
			end
			K_4444, K_N4444: begin
				lo = {w[3:0], 4'h0};
				g  = {w[7:4], 4'h0};
				hi = {w[11:8], 4'h0};
				a  = {w[15:12], 4'h0};
				if (q_item.kind == K_N4444) begin
					a = a ^ ALPHA_OPAQUE;
				end
			end
			K_8888:  a = w[31:24];
			K_N8888: a = w[31:24] ^ ALPHA_OPAQUE;
			K_GRAY: begin
				g  = w[7:0];
				hi = w[7:0];
			end
			default: a = ALPHA_OPAQUE;
		endcase
	end

	assign pop         = !q_status.empty && (!valid_q || !pixel_stall);
	assign pixel_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !pixel_stall) begin
			valid_q <= !q_status.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			green <= g;
			alpha <= a;
			if (q_item.rgb_order) begin
				red  <= lo;
				blue <= hi;
			end else begin
				red  <= hi;
				blue <= lo;
			end
		end
	end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for pixel_format_to_rgba8888_top: drives byte transfers under
// random idling, predicts every converted pixel with a scoreboard class and checks each one.
// Depends on pfc_pkg and the RTL under src.
`default_nettype none

module testbench;
	import pfc_pkg::*;

	localparam logic [FMT_W-1:0] FMT_BGR565     = 5'd2;
	localparam logic [FMT_W-1:0] FMT_BGR888X    = 5'd4;
	localparam logic [FMT_W-1:0] FMT_BGRA5551   = 5'd6;
	localparam logic [FMT_W-1:0] FMT_BGRNA8888  = 5'd10;
	localparam logic [FMT_W-1:0] FMT_RGBNA4444  = 5'd18;
	localparam logic [FMT_W-1:0] FMT_RGBNA5551  = 5'd19;
	localparam logic [FMT_W-1:0] FMT_UNKNOWN    = 5'd25;
	localparam logic [FMT_W-1:0] FMT_TOP_CODE   = 5'd31;
	localparam int               SETTLE_CYCLES  = 6;
	localparam int               HOLD_CYCLES    = 150;
	localparam int               RANDOM_PHASES  = 24;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	class pixel_scoreboard;
		logic [FMT_W-1:0] fmt      = FMT_RESET;
		logic [23:0]      gathered = '0;
		logic [1:0]       pos      = '0;
		rgba_t            expected_q[$];
		int               errors   = 0;

		function void set_format(logic [FMT_W-1:0] f);
			fmt      = f;
			gathered = '0;
			pos      = '0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// one accepted byte; pushes the converted pixel when it completes one
		function void note_byte(logic [7:0] b);
			kind_t       k;
			int unsigned n;
			logic [31:0] word;
			logic [15:0] w;
			logic [7:0]  lo, g, hi, a;
			rgba_t       px;
			if (fmt >= NUM_FORMATS) begin
				gathered = '0;
				pos      = '0;
				return;
			end
			k = (fmt == FMT_GRAY8) ? K_GRAY : kind_t'((fmt - 1) % 10);
			case (k)
				K_GRAY:                    n = 1;
				K_888:                     n = 3;
				K_888X, K_8888, K_N8888:   n = 4;
				default:                   n = 2;
			endcase
			if (pos + 1 < n) begin
				gathered = gathered | (24'(b) << (8 * pos));
				pos      = pos + 2'd1;
				return;
			end
			word     = {8'h00, gathered} | (32'(b) << (8 * pos));
			gathered = '0;
			pos      = '0;
			w        = word[15:0];
			a        = ALPHA_OPAQUE;
			case (k)
				K_GRAY: begin
					lo = b;
					g  = b;
					hi = b;
				end
				K_555X, K_5551, K_N5551: begin
					lo = {w[4:0], 3'b0};
					g  = {w[9:5], 3'b0};
					hi = {w[14:10], 3'b0};
					if (k == K_5551)
						a = w[15] ? ALPHA_OPAQUE : 8'h00;
					if (k == K_N5551)
						a = w[15] ? 8'h00 : ALPHA_OPAQUE;
				end
				K_565: begin
					lo = {w[4:0], 3'b0};
					g  = {w[10:5], 2'b0};
					hi = {w[15:11], 3'b0};
				end
				K_4444, K_N4444: begin
					lo = {w[3:0], 4'b0};
					g  = {w[7:4], 4'b0};
					hi = {w[11:8], 4'b0};
					a  = {w[15:12], 4'b0};
					if (k == K_N4444)
						a = a ^ 8'hFF;
				end
				default: begin
					lo = word[7:0];
					g  = word[15:8];
					hi = word[23:16];
					if (k == K_8888)
						a = word[31:24];
					if (k == K_N8888)
						a = word[31:24] ^ 8'hFF;
				end
			endcase
			px.green = g;
			px.alpha = a;
			if (fmt <= FMT_BGR_LAST) begin
				px.red  = hi;
				px.blue = lo;
			end else begin
				px.red  = lo;
				px.blue = hi;
			end
			expected_q.push_back(px);
		endfunction

		function void check_pixel(rgba_t got);
			rgba_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected pixel: r=%h g=%h b=%h a=%h",
						got.red, got.green, got.blue, got.alpha);
				return;
			end
			want = expected_q.pop_front();
			if (got.red !== want.red || got.green !== want.green ||
					got.blue !== want.blue || got.alpha !== want.alpha) begin
				errors++;
				if (errors <= 10)
					$display("pixel mismatch: expected r=%h g=%h b=%h a=%h, got r=%h g=%h b=%h a=%h",
						want.red, want.green, want.blue, want.alpha,
						got.red, got.green, got.blue, got.alpha);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [FMT_W-1:0] pixel_format;
	logic             data_valid;
	logic             data_stall;
	logic [7:0]       data_byte;
	logic             pixel_valid;
	logic             pixel_stall;
	logic [7:0]       red, green, blue, alpha;

	pixel_scoreboard sb;
	int              send_idle_pct;
	int              stall_pct;
	bit              hold_request;
	int              hold_left;

	pixel_format_to_rgba8888_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.pixel_format (pixel_format),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data_byte    (data_byte),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver stall, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			pixel_stall <= 1'b1;
			hold_left   = hold_left - 1;
		end else begin
			pixel_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pixel_valid && !pixel_stall)
			sb.check_pixel('{red, green, blue, alpha});
	end

	function automatic logic [7:0] random_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			data_valid <= 1'b0;
			@(negedge clk);
		end
		data_valid <= 1'b1;
		data_byte  <= b;
		do
			@(posedge clk);
		while (data_stall);
		sb.note_byte(b);
		@(negedge clk);
	endtask

	// n bytes of v, lowest byte first
	task automatic send_pixel(input int n, input logic [31:0] v);
		for (int i = 0; i < n; i++)
			send_byte(v[8*i +: 8]);
	endtask

	task automatic drain();
		data_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_format(input logic [FMT_W-1:0] f);
		drain();
		cfg_valid    <= 1'b1;
		pixel_format <= f;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_format(f);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int               nbytes;
		int               n;
		logic [FMT_W-1:0] f;
		sb            = new();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		pixel_format  = FMT_RESET;
		data_valid    = 1'b0;
		data_byte     = 8'h00;
		pixel_stall   = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_request  = 1'b0;
		hold_left     = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset format, alpha rules, ignored fourth byte, unknown code, dropped pixel
		send_pixel(4, 32'hFF221100);
		write_format(FMT_GRAY8);
		send_pixel(1, 32'h00);
		send_pixel(1, 32'hFF);
		write_format(FMT_BGRA5551);
		send_pixel(2, 32'h8000);
		send_pixel(2, 32'h7FFF);
		write_format(FMT_RGBNA5551);
		send_pixel(2, 32'h8000);
		write_format(FMT_RGBNA4444);
		send_pixel(2, 32'hF234);
		write_format(FMT_BGR888X);
		send_pixel(4, 32'h44332211);
		write_format(FMT_UNKNOWN);
		send_pixel(2, 32'h5AA5);
		write_format(FMT_BGR565);
		send_pixel(1, 32'h01);
		write_format(FMT_BGRNA8888);
		send_pixel(4, 32'h00FFFFFF);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       f = FMT_GRAY8;
				1:       f = FMT_RGB_LAST;
				2:       f = FMT_TOP_CODE;
				3:       f = FMT_BGR_FIRST;
				default: f = ($urandom_range(0, 7) == 0) ?
					FMT_W'($urandom_range(NUM_FORMATS, 31)) :
					FMT_W'($urandom_range(0, NUM_FORMATS - 1));
			endcase
			if (p == 13)
				f = FMT_W'($urandom_range(0, NUM_FORMATS - 1));
			write_format(f);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 73;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 73;
				end
				default: begin
					send_idle_pct = 17;
					stall_pct     = 17;
				end
			endcase
			// long receiver hold-off while bytes keep coming
			if (p == 0 || p == 13) begin
				@(posedge clk);
				hold_request = 1'b1;
				@(negedge clk);
			end
			nbytes = $urandom_range(56, 72);
			repeat (nbytes) send_byte(random_byte());
		end

		data_valid <= 1'b0;
		for (n = 0; n < 5000 && sb.pending() != 0; n++)
			@(negedge clk);
		sb.errors += sb.pending();
		repeat (SETTLE_CYCLES * 2) @(negedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
src/pfc_pkg.sv
src/pfc_front.sv
src/pfc_fifo.sv
src/pfc_back.sv
src/pixel_format_to_rgba8888_top.sv
dv/testbench.sv
